[sv/pli_pkg.sv]
// Shared types, widths and codes for the piecewise linear interpolator.
// No dependencies; every other file of the block but pli_ram imports this package.
package pli_pkg;

    localparam int DATA_W      = 32;
    localparam int MAX_POINTS  = 64;
    localparam int MIN_POINTS  = 2;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int DIFF_W      = DATA_W + 1;
    localparam int SUM_W       = DATA_W + 2;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int ENTRY_W     = 2 * DATA_W;
    localparam int STEP_W      = $clog2(DATA_W);
    localparam int REGION_W    = 2;

    // stream packing
    localparam int IN_IDX_LSB     = 0;
    localparam int IN_COORD_LSB   = IDX_W;
    localparam int IN_SAMPLE_LSB  = IDX_W + DATA_W;
    localparam int IN_DATA_BITS   = IDX_W + 2 * DATA_W;
    localparam int IN_TDATA_W     = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_VALUE_LSB  = 0;
    localparam int OUT_SEG_LSB    = DATA_W;
    localparam int OUT_DATA_BITS  = DATA_W + IDX_W;
    localparam int OUT_TDATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [CNT_W-1:0] POINT_COUNT_RST = CNT_W'(MIN_POINTS);

    localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [REGION_W-1:0] {
        REGION_INTERIOR = 2'd0,
        REGION_BELOW    = 2'd1,
        REGION_ABOVE    = 2'd2
    } t_region;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_FIRST,
        S_CHK_FIRST,
        S_CHK_LAST,
        S_CHK_SEG,
        S_WALK,
        S_DIFF,
        S_MAG,
        S_MUL_GO,
        S_MUL_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FIN,
        S_OUT
    } t_state;

    // divider status toward the sequencer
    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_stat;

endpackage

[sv/pli_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/pli_mul.sv]
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on pli_pkg.
module pli_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pli_pkg::DATA_W-1:0]  i_a,
    input  logic [pli_pkg::DATA_W-1:0]  i_b,
    output logic                        o_done,
    output logic [pli_pkg::PROD_W-1:0]  o_prod
);
    import pli_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_hi;
    logic [DATA_W-1:0] r_lo;
    logic [DATA_W:0]   sum;

    // add multiplicand when the current low bit is set
    assign sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : {(DATA_W+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(DATA_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= sum[DATA_W:1];
            r_lo <= {sum[0], r_lo[DATA_W-1:1]};
        end
    end

    assign o_done = r_busy && (r_step == STEP_W'(DATA_W - 1));
    assign o_prod = {r_hi, r_lo};

endmodule

[sv/pli_div.sv]
// Bit-serial restoring divider: double-width dividend over single-width divisor,
// one quotient bit per cycle; flags a quotient that does not fit. Depends on pli_pkg.
module pli_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pli_pkg::PROD_W-1:0]  i_dividend,
    input  logic [pli_pkg::DATA_W-1:0]  i_divisor,
    output pli_pkg::t_div_stat          o_stat,
    output logic [pli_pkg::DATA_W-1:0]  o_quo
);
    import pli_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_q;
    logic [DATA_W-1:0] r_d;
    logic              r_ovf;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              fits;

    assign trial = {r_rem, r_q[DATA_W-1]};
    assign fits  = trial >= {1'b0, r_d};
    assign diff  = trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(DATA_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // upper half at or above divisor means quotient >= 2^DATA_W
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[PROD_W-1:DATA_W];
            r_q   <= i_dividend[DATA_W-1:0];
            r_d   <= i_divisor;
            r_ovf <= i_dividend[PROD_W-1:DATA_W] >= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            r_q   <= {r_q[DATA_W-2:0], fits};
        end
    end

    assign o_stat.done = r_busy && (r_step == STEP_W'(DATA_W - 1));
    assign o_stat.ovf  = r_ovf;
    assign o_quo       = r_q;

endmodule

[sv/piecewise_linear_interpolator.sv]
// Piecewise linear interpolator over a breakpoint table, clamped at the ends.
// Depends on pli_pkg, pli_ram, pli_mul and pli_div.
//
// Usage:
//   s_axis carries items in: tuser = func (load / query), tdata = point_index,
//   coordinate, sample_value. A load writes one breakpoint into the table and
//   makes no result. A query makes one m_axis item: tdata = interpolated_value,
//   segment_used; tuser = region (interior, clamped below, clamped above).
//   The cfg channel writes point_count (2..64, out-of-range values are clamped);
//   it is always ready; the user must write it only while the block is idle,
//   which the block does not enforce.
// Query time:
//   A clamped query finishes sooner than an interior one, whose time grows
//   with the segments walked past the remembered one and is set by the
//   bit-serial multiplier and divider and by the walk, which reads one table
//   entry per cycle through the single RAM read port.
//   One query is in flight at a time.
// Reset: the search segment returns to 0, point_count to 2, output goes idle.
//   Table contents are not cleared; only written entries may be queried.
// Stall: the result sits in an output register; loads are still taken while it
//   waits, and a finished query waits in place until that register frees up.
module piecewise_linear_interpolator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // point_index, coordinate, sample_value (from bit 0 up), zero padded
    input  logic [pli_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // func
    input  logic                             s_axis_tuser,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // interpolated_value, segment_used (from bit 0 up), zero padded
    output logic [pli_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // region
    output logic [pli_pkg::REGION_W-1:0]     m_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [pli_pkg::CNT_W-1:0]        i_cfg_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready
);
    import pli_pkg::*;

    // control state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_point_count;
    logic [IDX_W-1:0]   r_search;
    logic               r_out_valid;

    // query payload
    logic signed [DATA_W-1:0] r_q;
    logic [IDX_W-1:0]         r_last;
    logic [IDX_W-1:0]         r_seg;
    logic signed [DATA_W-1:0] r_x0, r_v0;     // entry 0, kept for a restart
    logic signed [DATA_W-1:0] r_xa, r_va;     // left breakpoint
    logic signed [DATA_W-1:0] r_xb, r_vb;     // right breakpoint
    logic signed [DIFF_W-1:0] r_dq, r_dv, r_dx;
    logic [DATA_W-1:0]        r_mq, r_mv, r_mx;
    logic                     r_neg;
    logic signed [DATA_W-1:0] r_res;
    t_region                  r_region;

    // output register
    logic [DATA_W-1:0]        r_out_value;
    logic [IDX_W-1:0]         r_out_seg;
    t_region                  r_out_region;

    // table port
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_raddr;
    logic [ENTRY_W-1:0]       ram_rdata;
    logic signed [DATA_W-1:0] rd_x, rd_v;

    // arithmetic units
    logic                     mul_start, mul_done;
    logic [PROD_W-1:0]        mul_prod;
    logic                     div_start;
    t_div_stat                div_stat;
    logic [DATA_W-1:0]        div_quo;

    logic                     in_acc, is_query, out_free;
    logic [CNT_W-1:0]         count_clamped;
    logic [IDX_W-1:0]         last_m1, seg_start, seg_pick;
    logic                     q_le_rd, q_ge_rd, q_lt_rd, q_gt_rd, walk_more;
    logic signed [SUM_W-1:0]  sum_wide;
    logic signed [DATA_W-1:0] fin_value;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_query      = (s_axis_tuser == FUNC_QUERY);
    assign out_free      = !r_out_valid || m_axis_tready;

    assign ram_we = in_acc && (s_axis_tuser == FUNC_LOAD);

    pli_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (s_axis_tdata[IN_IDX_LSB +: IDX_W]),
        .i_wdata ({s_axis_tdata[IN_SAMPLE_LSB +: DATA_W],
                   s_axis_tdata[IN_COORD_LSB +: DATA_W]}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[DATA_W-1:0];
    assign rd_v = ram_rdata[ENTRY_W-1:DATA_W];

    pli_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (r_mq),
        .i_b     (r_mv),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    pli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mul_prod),
        .i_divisor  (r_mx),
        .o_stat     (div_stat),
        .o_quo      (div_quo)
    );

    // active point count, clamped to the table
    always_comb begin
        if (r_point_count < CNT_W'(MIN_POINTS)) begin
            count_clamped = CNT_W'(MIN_POINTS);
        end else if (r_point_count > CNT_W'(MAX_POINTS)) begin
            count_clamped = CNT_W'(MAX_POINTS);
        end else begin
            count_clamped = r_point_count;
        end
    end

    assign last_m1   = r_last - 1'b1;
    assign q_le_rd   = r_q <= rd_x;
    assign q_ge_rd   = r_q >= rd_x;
    assign q_lt_rd   = r_q <  rd_x;
    assign q_gt_rd   = r_q >  rd_x;
    // remembered segment, restarted when past the active table
    assign seg_start = (r_search > last_m1) ? '0 : r_search;
    // restart from segment 0 when the query lies left of the remembered one
    assign seg_pick  = q_lt_rd ? '0 : r_seg;
    assign walk_more = (r_seg < last_m1) && q_gt_rd;

    // left breakpoint value +/- quotient, then saturate
    assign sum_wide = r_neg ? (SUM_W'(r_va) - $signed({2'b00, div_quo}))
                            : (SUM_W'(r_va) + $signed({2'b00, div_quo}));

    always_comb begin
        if (div_stat.ovf) begin
            fin_value = r_neg ? VALUE_MIN : VALUE_MAX;
        end else if (sum_wide > SUM_W'(VALUE_MAX)) begin
            fin_value = VALUE_MAX;
        end else if (sum_wide < SUM_W'(VALUE_MIN)) begin
            fin_value = VALUE_MIN;
        end else begin
            fin_value = sum_wide[DATA_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (in_acc && is_query) n_state = S_RD_FIRST;
            S_RD_FIRST:  n_state = S_CHK_FIRST;
            S_CHK_FIRST: n_state = q_le_rd ? S_OUT : S_CHK_LAST;
            S_CHK_LAST:  n_state = q_ge_rd ? S_OUT : S_CHK_SEG;
            S_CHK_SEG:   n_state = S_WALK;
            S_WALK:      n_state = walk_more ? S_WALK : S_DIFF;
            S_DIFF:      n_state = S_MAG;
            S_MAG:       n_state = (r_dx == '0) ? S_OUT : S_MUL_GO;
            S_MUL_GO:    n_state = S_MUL_WAIT;
            S_MUL_WAIT:  if (mul_done) n_state = S_DIV_GO;
            S_DIV_GO:    n_state = S_DIV_WAIT;
            S_DIV_WAIT:  if (div_stat.done) n_state = S_FIN;
            S_FIN:       n_state = S_OUT;
            S_OUT:       if (out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // state outputs: read address, unit starts
    always_comb begin
        ram_raddr = '0;
        mul_start = 1'b0;
        div_start = 1'b0;
        case (r_state)
            S_RD_FIRST:  ram_raddr = '0;
            S_CHK_FIRST: ram_raddr = r_last;
            S_CHK_LAST:  ram_raddr = seg_start;
            S_CHK_SEG:   ram_raddr = seg_pick + 1'b1;
            S_WALK:      ram_raddr = r_seg + IDX_W'(2);
            S_MUL_GO:    mul_start = 1'b1;
            S_DIV_GO:    div_start = 1'b1;
            default:     ram_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_point_count <= POINT_COUNT_RST;
            r_search      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_point_count <= i_cfg_data;
            end
            if (r_state == S_WALK && !walk_more) begin
                r_search <= r_seg;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // query datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc && is_query) begin
                    r_q    <= s_axis_tdata[IN_COORD_LSB +: DATA_W];
                    r_last <= IDX_W'(count_clamped - 1'b1);
                end
            end
            S_CHK_FIRST: begin
                r_x0 <= rd_x;
                r_v0 <= rd_v;
                if (q_le_rd) begin
                    r_res    <= rd_v;
                    r_region <= REGION_BELOW;
                    r_seg    <= '0;
                end
            end
            S_CHK_LAST: begin
                if (q_ge_rd) begin
                    r_res    <= rd_v;
                    r_region <= REGION_ABOVE;
                    r_seg    <= last_m1;
                end else begin
                    r_seg <= seg_start;
                end
            end
            S_CHK_SEG: begin
                r_seg <= seg_pick;
                if (q_lt_rd) begin
                    r_xa <= r_x0;
                    r_va <= r_v0;
                end else begin
                    r_xa <= rd_x;
                    r_va <= rd_v;
                end
            end
            S_WALK: begin
                if (walk_more) begin
                    r_seg <= r_seg + 1'b1;
                    r_xa  <= rd_x;
                    r_va  <= rd_v;
                end else begin
                    r_xb <= rd_x;
                    r_vb <= rd_v;
                end
            end
            S_DIFF: begin
                r_dq     <= DIFF_W'(r_q)  - DIFF_W'(r_xa);
                r_dv     <= DIFF_W'(r_vb) - DIFF_W'(r_va);
                r_dx     <= DIFF_W'(r_xb) - DIFF_W'(r_xa);
                r_region <= REGION_INTERIOR;
            end
            S_MAG: begin
                // differences of two DATA_W values stay below 2^DATA_W in magnitude
                r_mq  <= r_dq[DIFF_W-1] ? DATA_W'(-r_dq) : r_dq[DATA_W-1:0];
                r_mv  <= r_dv[DIFF_W-1] ? DATA_W'(-r_dv) : r_dv[DATA_W-1:0];
                r_mx  <= r_dx[DIFF_W-1] ? DATA_W'(-r_dx) : r_dx[DATA_W-1:0];
                r_neg <= r_dq[DIFF_W-1] ^ r_dv[DIFF_W-1] ^ r_dx[DIFF_W-1];
                if (r_dx == '0) begin
                    r_res <= r_va;     // zero-width segment
                end
            end
            S_FIN: begin
                r_res <= fin_value;
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_value  <= r_res;
            r_out_seg    <= r_seg;
            r_out_region <= r_region;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_region;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_seg, r_out_value});

endmodule

[sv/pli_checker.sv]
// Port-level checks for the piecewise linear interpolator, bound to the top level.
// Depends on pli_pkg and piecewise_linear_interpolator.
module pli_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [pli_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tuser,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [pli_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic [pli_pkg::REGION_W-1:0]     m_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [pli_pkg::CNT_W-1:0]        i_cfg_data,
    input  logic                             i_cfg_valid,
    input  logic                             o_cfg_ready
);
    import pli_pkg::*;

    // a result is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one query at a time: input closes right after a query is taken
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_QUERY) |=> !s_axis_tready)
        else $error("input open during a query");

    // clamped below always reports the first segment
    a_below_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == REGION_BELOW)
        |-> (m_axis_tdata[OUT_SEG_LSB +: IDX_W] == '0))
        else $error("clamp below with nonzero segment");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (.*);
